// ----- design/greedy_row_path_selector_defines.svh -----
// ----------------------------------------------------------------------------
// Greedy row path selector assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef GREEDY_ROW_PATH_SELECTOR_DEFINES_SVH
`define GREEDY_ROW_PATH_SELECTOR_DEFINES_SVH

// Invariant that must hold at every clock edge out of reset.
`define GRPS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define GRPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define GRPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/grps_pkg.sv -----
// ----------------------------------------------------------------------------
// Greedy row path selector package
// Field widths, the cell and result word types shared by all modules.
// ----------------------------------------------------------------------------
`default_nettype none

package grps_pkg;

    localparam int COST_W  = 16;
    localparam int COL_W   = 4;
    localparam int ROW_W   = 7;
    localparam int SCORE_W = 17;
    localparam int TOTAL_W = 32;

    // Output word: row_number, chosen_column, step_weight, path_total, padded.
    localparam int RES_W   = ROW_W + COL_W + SCORE_W + TOTAL_W;
    localparam int OUT_W   = ((RES_W + 7) / 8) * 8;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // One accepted input word.
    typedef struct packed {
        logic [COST_W-1:0] cell_cost;
        logic              row_end;
        logic              path_start;
    } t_cell;

    // One row result.
    typedef struct packed {
        logic [TOTAL_W-1:0] path_total;
        logic [SCORE_W-1:0] step_weight;
        logic [COL_W-1:0]   chosen_column;
        logic [ROW_W-1:0]   row_number;
    } t_result;

endpackage

`default_nettype wire

// ----- design/grps_in_stage.sv -----
// ----------------------------------------------------------------------------
// Input register stage
// Captures one cell word and holds it until the row core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module grps_in_stage
    import grps_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_cell i_cell,
    input  wire logic  i_take,
    output logic       o_valid,
    output t_cell      o_cell
);

    logic  r_valid;
    t_cell r_cell;

    // A new word may enter when the stage is empty or drains this cycle.
    assign o_ready = !r_valid || i_take;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cell <= i_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

`default_nettype wire

// ----- design/grps_row_core.sv -----
// ----------------------------------------------------------------------------
// Row scoring core
// Scores each cell against the current position, tracks the row minimum and
// the saturating path total, and forms the result at the end of a row.
// ----------------------------------------------------------------------------
`default_nettype none

module grps_row_core
    import grps_pkg::*;
#(
    parameter int COLUMNS = 12,
    parameter int ROWS    = 128
)
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_cell i_cell,
    input  wire logic  i_out_free,
    output logic       o_take,
    output logic       o_load,
    output t_result    o_result
);

`include "greedy_row_path_selector_defines.svh"

    localparam logic [COL_W-1:0] LastCol = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LastRow = ROW_W'(ROWS - 1);

    logic [COL_W-1:0]   r_cur;
    logic [COL_W-1:0]   r_scan;
    logic [SCORE_W-1:0] r_best;
    logic [COL_W-1:0]   r_bcol;
    logic [TOTAL_W-1:0] r_total;
    logic [ROW_W-1:0]   r_row;

    logic [COL_W-1:0]   cur_eff;
    logic [COL_W-1:0]   scan_eff;
    logic [SCORE_W-1:0] best_eff;
    logic [COL_W-1:0]   bcol_eff;
    logic [TOTAL_W-1:0] total_eff;
    logic [ROW_W-1:0]   row_eff;
    logic [COL_W-1:0]   col_dist;
    logic [SCORE_W-1:0] score;
    logic               take_cell;
    logic [SCORE_W-1:0] n_best;
    logic [COL_W-1:0]   n_bcol;
    logic [TOTAL_W:0]   sum_wide;
    logic [TOTAL_W-1:0] n_total;

    // A word moves on when it needs no result slot or the slot is free.
    assign o_take = i_valid && (!i_cell.row_end || i_out_free);
    assign o_load = o_take && i_cell.row_end;

    // A path start clears the state before this cell is scored.
    always_comb begin
        cur_eff   = i_cell.path_start ? '0 : r_cur;
        scan_eff  = i_cell.path_start ? '0 : r_scan;
        best_eff  = i_cell.path_start ? '0 : r_best;
        bcol_eff  = i_cell.path_start ? '0 : r_bcol;
        total_eff = i_cell.path_start ? '0 : r_total;
        row_eff   = i_cell.path_start ? '0 : r_row;
    end

    // Score and running minimum; the first cell of a row always wins.
    always_comb begin
        col_dist  = (scan_eff >= cur_eff) ? (scan_eff - cur_eff) : (cur_eff - scan_eff);
        score     = {1'b0, i_cell.cell_cost} + SCORE_W'(col_dist);
        take_cell = (scan_eff == '0) || (score < best_eff);
        n_best    = take_cell ? score : best_eff;
        n_bcol    = take_cell ? scan_eff : bcol_eff;
    end

    // Saturating path total.
    always_comb begin
        sum_wide = {1'b0, total_eff} + (TOTAL_W + 1)'(n_best);
        n_total  = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
    end

    // Row result.
    always_comb begin
        o_result.row_number    = row_eff;
        o_result.chosen_column = n_bcol;
        o_result.step_weight   = n_best;
        o_result.path_total    = n_total;
    end

    // State update on each consumed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_scan  <= '0;
            r_best  <= '0;
            r_bcol  <= '0;
            r_total <= '0;
            r_row   <= '0;
        end else if (o_take) begin
            if (i_cell.row_end) begin
                r_cur   <= n_bcol;
                r_scan  <= '0;
                r_best  <= '0;
                r_bcol  <= '0;
                r_total <= n_total;
                r_row   <= (row_eff < LastRow) ? row_eff + 1'b1 : row_eff;
            end else begin
                r_cur   <= cur_eff;
                r_scan  <= (scan_eff < LastCol) ? scan_eff + 1'b1 : scan_eff;
                r_best  <= n_best;
                r_bcol  <= n_bcol;
                r_total <= total_eff;
                r_row   <= row_eff;
            end
        end
    end

    `GRPS_ASSERT_ALWAYS(a_scan_range, r_scan <= LastCol, "scan column past last column")
    `GRPS_ASSERT_ALWAYS(a_row_range, r_row <= LastRow, "row counter past last row")
    `GRPS_ASSERT_SAME(a_row_start_clear, r_scan == '0, r_best == '0 && r_bcol == '0,
        "row minimum not cleared at row start")
    `GRPS_ASSERT_NEXT(a_row_end_rewind, o_load, r_scan == '0 && r_cur == $past(n_bcol),
        "row end did not rewind scan or move position")

endmodule

`default_nettype wire

// ----- design/grps_out_stage.sv -----
// ----------------------------------------------------------------------------
// Output register stage
// Holds one row result word until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module grps_out_stage
    import grps_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_ready,
    output logic         o_free,
    output logic         o_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    // The slot can take a new result when empty or being read out now.
    assign o_free = !r_valid || i_ready;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- design/greedy_row_path_selector.sv -----
// A row_end word passes from the input register through the row core into the
// output register. Throughput: one cell word per cycle; each register holds one
// word, and a stalled result stops a row_end word in the input register and with
// it all input. Reset: i_rst_n is synchronous and active low; it empties both
// registers and clears position, scan, row minimum, total and row count to zero.
// ----------------------------------------------------------------------------
// Greedy row path selector
// Streams grid cell costs row by row and reports the greedy column per row.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_row_path_selector
    import grps_pkg::*;
#(
    parameter int COLUMNS = 12,
    parameter int ROWS    = 128
)
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [COST_W-1:0]  s_axis_tdata,   // [15:0] cell_cost
    input  wire logic               s_axis_tlast,   // row_end
    input  wire logic [0:0]         s_axis_tuser,   // [0] path_start
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [6:0] row_number, [10:7] chosen_column, [27:11] step_weight,
    // [59:28] path_total, [63:60] zero
    output logic [OUT_W-1:0]        m_axis_tdata
);

`include "greedy_row_path_selector_defines.svh"

    t_cell   in_word;
    t_cell   cell_q;
    logic    cell_valid;
    logic    take;
    logic    load;
    logic    out_free;
    t_result result_d;
    t_result result_q;

    assign in_word.cell_cost  = s_axis_tdata;
    assign in_word.row_end    = s_axis_tlast;
    assign in_word.path_start = s_axis_tuser[0];

    // Input register.
    grps_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cell  (in_word),
        .i_take  (take),
        .o_valid (cell_valid),
        .o_cell  (cell_q)
    );

    // Scoring and path state.
    grps_row_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (cell_valid),
        .i_cell     (cell_q),
        .i_out_free (out_free),
        .o_take     (take),
        .o_load     (load),
        .o_result   (result_d)
    );

    // Result register.
    grps_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_result (result_d),
        .i_ready  (m_axis_tready),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .o_result (result_q)
    );

    // Pack the result word, first field lowest.
    assign m_axis_tdata = OUT_W'(result_q);

    `GRPS_ASSERT_NEXT(a_row_end_held, cell_valid && cell_q.row_end && m_axis_tvalid
        && !m_axis_tready, cell_valid && cell_q.row_end, "row end dropped while output stalled")

endmodule

`default_nettype wire
